// ----- src/rbf_kernel_eval_top_macros.svh -----
// Assertion macros for the kernel evaluator checker.
`ifndef RBF_KERNEL_EVAL_TOP_MACROS_SVH
`define RBF_KERNEL_EVAL_TOP_MACROS_SVH

// Same-cycle implication, inactive while reset is asserted.
`define RBF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, inactive while reset is asserted.
`define RBF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked through reset.
`define RBF_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/rbf_pkg.sv -----
package rbf_pkg;

  // Field and datapath widths.
  localparam int ELEM_W  = 16;
  localparam int GAMMA_W = 16;
  localparam int ACC_W   = 40;
  localparam int SQ_W    = 32;
  localparam int KVAL_W  = 16;
  localparam int VAL_W   = 32;
  localparam int TAB_W   = 31;
  localparam int TBITS   = 24;
  localparam int IDX_W   = 5;
  localparam int HALF_W  = 20;
  localparam int PP_W    = GAMMA_W + HALF_W;
  localparam int PROD_W  = GAMMA_W + ACC_W;

  localparam logic [GAMMA_W-1:0] GAMMA_RESET = 16'd4096;
  localparam logic [VAL_W-1:0]   ONE_Q31     = 32'h8000_0000;

  // exp(-2^-m) in Q1.31 from the alternating Taylor series in Q.60.
  function automatic logic [63:0] exp_neg_pow2(input int unsigned m);
    logic [63:0] term;
    logic [63:0] total;
    logic        done;
    term  = 64'd1 << 60;
    total = 64'd1 << 60;
    done  = 1'b0;
    for (int n = 1; n < 48; n++) begin
      if (!done) begin
        term = (term >> m) / 64'(n);
        if (term == 64'd0) begin
          done = 1'b1;
        end else if (n[0]) begin
          total = total - term;
        end else begin
          total = total + term;
        end
      end
    end
    return (total + (64'd1 << 28)) >> 29;
  endfunction

  // Factor for bit b of the Q4.20 argument; the top four come from squaring.
  function automatic logic [63:0] exp_entry(input int unsigned b);
    logic [63:0] v;
    if (b < 20) begin
      v = exp_neg_pow2(20 - b);
    end else begin
      v = exp_neg_pow2(1);
      for (int k = 20; k < TBITS; k++) begin
        if (k <= int'(b)) begin
          v = (v * v + (64'd1 << 30)) >> 31;
        end
      end
    end
    return v;
  endfunction

  localparam logic [TAB_W-1:0] EXP_TAB [TBITS] = '{
    TAB_W'(exp_entry(0)),  TAB_W'(exp_entry(1)),  TAB_W'(exp_entry(2)),
    TAB_W'(exp_entry(3)),  TAB_W'(exp_entry(4)),  TAB_W'(exp_entry(5)),
    TAB_W'(exp_entry(6)),  TAB_W'(exp_entry(7)),  TAB_W'(exp_entry(8)),
    TAB_W'(exp_entry(9)),  TAB_W'(exp_entry(10)), TAB_W'(exp_entry(11)),
    TAB_W'(exp_entry(12)), TAB_W'(exp_entry(13)), TAB_W'(exp_entry(14)),
    TAB_W'(exp_entry(15)), TAB_W'(exp_entry(16)), TAB_W'(exp_entry(17)),
    TAB_W'(exp_entry(18)), TAB_W'(exp_entry(19)), TAB_W'(exp_entry(20)),
    TAB_W'(exp_entry(21)), TAB_W'(exp_entry(22)), TAB_W'(exp_entry(23))
  };

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             take;
    logic             mul_lo;
    logic             mul_hi;
    logic             exp_step;
    logic [IDX_W-1:0] bit_idx;
    logic             load_out;
  } rbf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } rbf_sts_t;

endpackage

// ----- src/rbf_ctrl.sv -----
module rbf_ctrl
  import rbf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_last,
  output logic     in_ready,
  input  rbf_sts_t sts,
  output rbf_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_ACC    = 6'b000001,
    S_DRAIN  = 6'b000010,
    S_MUL_LO = 6'b000100,
    S_MUL_HI = 6'b001000,
    S_EXP    = 6'b010000,
    S_OUT    = 6'b100000
  } rbf_state_t;

  rbf_state_t       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             take;

  assign in_ready = (state_r == S_ACC);
  assign take     = in_valid && in_ready;

  // Next-state and command decode.
  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    cmd          = '0;
    cmd.take     = take;
    cmd.bit_idx  = idx_r;
    case (state_r)
      S_ACC: begin
        if (take && in_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        idx_nxt    = '0;
        state_nxt  = S_EXP;
      end
      S_EXP: begin
        cmd.exp_step = 1'b1;
        idx_nxt      = IDX_W'(idx_r + 1'b1);
        if (idx_r == IDX_W'(TBITS - 1)) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_ACC;
        end
      end
      default: begin
        state_nxt = S_ACC;
      end
    endcase
  end

  // State and bit counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_ACC;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

// ----- src/rbf_dpath.sv -----
module rbf_dpath
  import rbf_pkg::*;
#(
  parameter int MAX_DIM = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [GAMMA_W-1:0] cfg_wr_data,
  input  logic [ELEM_W-1:0] in_x_elem,
  input  logic [ELEM_W-1:0] in_y_elem,
  input  rbf_cmd_t          cmd,
  output rbf_sts_t          sts,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [KVAL_W-1:0] out_kernel_value,
  output logic              out_overflow
);

  localparam int CNT_W = $clog2(MAX_DIM + 1);

  logic [GAMMA_W-1:0] gamma_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               cnt_ok;
  logic signed [ELEM_W:0] diff;
  logic [ELEM_W:0]    mag;
  logic [SQ_W-1:0]    sq_r;
  logic               sq_vld_r;
  logic [ACC_W:0]     sum;
  logic [ACC_W-1:0]   acc_r;
  logic               ovf_r;
  logic [PP_W-1:0]    lo_r;
  logic [PP_W-1:0]    hi_w;
  logic [PROD_W-1:0]  prod;
  logic [TBITS-1:0]   t_r;
  logic               big_r;
  logic [VAL_W-1:0]   val_r;
  logic [62:0]        eprod;
  logic [VAL_W-1:0]   rnd;
  logic               out_valid_r;
  logic [KVAL_W-1:0]  kval_r;
  logic               oflag_r;

  // Kernel width register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_r <= GAMMA_RESET;
    end else if (cfg_wr_en) begin
      gamma_r <= cfg_wr_data;
    end
  end

  // First stage: difference and its square.
  assign cnt_ok = (cnt_r < CNT_W'(MAX_DIM));
  assign diff   = $signed({in_x_elem[ELEM_W-1], in_x_elem}) -
                  $signed({in_y_elem[ELEM_W-1], in_y_elem});
  assign mag    = diff[ELEM_W] ? (ELEM_W+1)'(-diff) : (ELEM_W+1)'(diff);

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      sq_r <= SQ_W'(mag) * SQ_W'(mag);
    end
  end

  // Second stage: saturating accumulate, element count and sticky flag.
  assign sum = {1'b0, acc_r} + (ACC_W+1)'(sq_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r <= 1'b0;
      cnt_r    <= '0;
      acc_r    <= '0;
      ovf_r    <= 1'b0;
    end else if (cmd.load_out) begin
      sq_vld_r <= 1'b0;
      cnt_r    <= '0;
      acc_r    <= '0;
      ovf_r    <= 1'b0;
    end else begin
      sq_vld_r <= cmd.take && cnt_ok;
      if (cmd.take && cnt_ok) begin
        cnt_r <= CNT_W'(cnt_r + 1'b1);
      end
      // The flag sticks for a skipped pair or a saturated sum.
      if ((cmd.take && !cnt_ok) || (sq_vld_r && sum[ACC_W])) begin
        ovf_r <= 1'b1;
      end
      if (sq_vld_r) begin
        acc_r <= sum[ACC_W] ? '1 : sum[ACC_W-1:0];
      end
    end
  end

  // gamma * distance in two partial products.
  assign hi_w = PP_W'(gamma_r) * PP_W'(acc_r[ACC_W-1:HALF_W]);
  assign prod = {hi_w, {HALF_W{1'b0}}} + PROD_W'(lo_r);

  // Exponent loop: one rounded Q1.31 product for each set argument bit.
  assign eprod = 63'(val_r) * 63'(EXP_TAB[cmd.bit_idx]);

  always_ff @(posedge clk) begin
    if (cmd.mul_lo) begin
      lo_r <= PP_W'(gamma_r) * PP_W'(acc_r[HALF_W-1:0]);
    end
    if (cmd.mul_hi) begin
      t_r   <= prod[37:14];
      big_r <= (prod[PROD_W-1:38] != '0);
      val_r <= ONE_Q31;
    end else if (cmd.exp_step && t_r[cmd.bit_idx]) begin
      val_r <= VAL_W'((eprod + 63'(64'd1 << 30)) >> 31);
    end
  end

  // Output register, rounded to Q1.15.
  assign rnd          = val_r + VAL_W'(32'd1 << 15);
  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      kval_r  <= big_r ? '0 : rnd[VAL_W-1:16];
      oflag_r <= ovf_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kernel_value = kval_r;
  assign out_overflow     = oflag_r;

endmodule

// ----- src/rbf_kernel_eval_top.sv -----
// Gaussian RBF kernel evaluator.
// The input channel (in_valid/in_ready) carries one request per element pair:
// in_x_elem and in_y_elem as signed Q4.11, and in_last on the final pair.
// Each of the first MAX_DIM pairs adds (x - y)^2 to a 40-bit saturating
// distance accumulator. Pairs stream at one per cycle until the request with
// in_last is taken. The block then forms gamma * distance from two partial
// products and runs a 24-step exponent loop on one 32 x 31 multiplier, one
// argument bit per cycle. The result appears on out_valid after the drain,
// multiply, exponent and output states; in_ready is low from the last pair
// until the result is loaded. out_kernel_value is exp(-t) in unsigned Q1.15
// and out_overflow flags more than MAX_DIM pairs or a saturated accumulator.
// The user must write the gamma register (Q4.12) by cfg_wr_en/cfg_wr_data
// only between vectors; the block itself does not enforce this. A stalled
// result holds in the output register; accumulation of the next vector
// proceeds, and only its final result waits for the slot. Synchronous reset
// clears the accumulator, the count, the output valid and sets gamma to 1.0.
module rbf_kernel_eval_top
  import rbf_pkg::*;
#(
  parameter int MAX_DIM = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [GAMMA_W-1:0] cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [ELEM_W-1:0]  in_x_elem,
  input  logic [ELEM_W-1:0]  in_y_elem,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [KVAL_W-1:0]  out_kernel_value,
  output logic               out_overflow
);

  rbf_cmd_t cmd;
  rbf_sts_t sts;

  // Sequencer for accumulate, multiply, exponent and output load.
  rbf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_last),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Arithmetic and output register.
  rbf_dpath #(
    .MAX_DIM (MAX_DIM)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_x_elem        (in_x_elem),
    .in_y_elem        (in_y_elem),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kernel_value (out_kernel_value),
    .out_overflow     (out_overflow)
  );

endmodule

// ----- src/rbf_chk.sv -----
module rbf_chk
  import rbf_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_last,
  input logic              out_valid,
  input logic              out_ready,
  input logic [KVAL_W-1:0] out_kernel_value,
  input logic              out_overflow
);

`include "rbf_kernel_eval_top_macros.svh"

  // A stalled result keeps its payload.
  `RBF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_kernel_value) && $stable(out_overflow), "result changed while stalled")

  // The kernel value never exceeds 1.0 in Q1.15.
  `RBF_ASSERT_NOW(a_kval_range, out_valid, out_kernel_value <= 16'd32768, "kernel value above one")

  // Taking the last pair stops intake while the kernel is computed.
  `RBF_ASSERT_NEXT(a_last_stall, in_valid && in_ready && in_last, !in_ready, "intake continued after last pair")

  // A new result only follows a computation phase with intake stopped.
  `RBF_ASSERT_NOW(a_rise_busy, $rose(out_valid), !$past(in_ready), "result without computation phase")

  // Reset leaves no result pending.
  `RBF_ASSERT_ALWAYS(a_reset_clear, !rst_n, !out_valid, "result valid after reset")

endmodule

bind rbf_kernel_eval_top rbf_chk u_chk (.*);
